// File: design/llc_pkg.sv
// ----------------------------------------------------------------------------
// llc_pkg
// Shared types and codes for the link lifecycle controller.
// ----------------------------------------------------------------------------
package llc_pkg;

  // Lifecycle states, coded as they appear on the result channel.
  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_SCAN       = 4'd1,
    ST_CONNECTING = 4'd2,
    ST_DISCOVER   = 4'd3,
    ST_PAIR       = 4'd4,
    ST_SUBSCRIBE  = 4'd5,
    ST_READY      = 4'd6,
    ST_BOND       = 4'd7,
    ST_ERROR      = 4'd8
  } state_t;

  // Input command codes.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_MSG   = 3'd4;

  // Operation outcome codes carried by a tick.
  localparam logic [1:0] RES_DONE = 2'd1;
  localparam logic [1:0] RES_FAIL = 2'd2;

  // Result event codes.
  localparam logic [1:0] EV_STATE  = 2'd0;
  localparam logic [1:0] EV_DISC   = 2'd1;
  localparam logic [1:0] EV_MSG    = 2'd2;
  localparam logic [1:0] EV_SEND   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RECONNECT = 2'd0;
  localparam logic [1:0] CFG_SECURE    = 2'd1;
  localparam logic [1:0] CFG_TICK      = 2'd2;

  localparam logic [15:0] RECONNECT_RST = 16'd1500;
  localparam logic [15:0] SECURE_RST    = 16'd4000;
  localparam logic [9:0]  TICK_RST      = 10'd100;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  op_result;
    logic        link_up;
    logic        msg_is_button;
    logic [3:0]  msg_kind;
    logic [31:0] msg_seq;
    logic        send_kind;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  new_state;
    logic [3:0]  msg_kind;
    logic [31:0] msg_seq;
    logic        send_granted;
    logic        send_which;
    logic        teardown;
    logic        last;
  } result_t;

  // Results produced by one transaction: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } res_bundle_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

// File: design/llc_core.sv
// ----------------------------------------------------------------------------
// llc_core
// Lifecycle state, configuration registers and the per-transaction decision.
// ----------------------------------------------------------------------------
module llc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  llc_pkg::cfg_wr_t     cfg,
  input  llc_pkg::item_t       item,
  input  logic                 commit,
  output llc_pkg::res_bundle_t res
);
  import llc_pkg::*;

  state_t      state_r, state_nxt;
  logic        running_r, running_nxt;
  logic [15:0] tis_r, tis_nxt;
  logic [31:0] last_seq_r, last_seq_nxt;
  logic        seq_valid_r, seq_valid_nxt;

  logic [15:0] reconnect_r;
  logic [15:0] secure_r;
  logic [9:0]  tick_period_r;

  logic [16:0] t_sum;
  logic [15:0] t_sat;
  state_t      target;
  logic        target_td;
  logic        link_drop;
  result_t     blank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reconnect_r   <= RECONNECT_RST;
      secure_r      <= SECURE_RST;
      tick_period_r <= TICK_RST;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_RECONNECT: reconnect_r   <= cfg.data;
        CFG_SECURE:    secure_r      <= cfg.data;
        CFG_TICK:      tick_period_r <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= 1'b0;
      tis_r       <= '0;
      last_seq_r  <= '0;
      seq_valid_r <= 1'b0;
    end else if (commit) begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      tis_r       <= tis_nxt;
      last_seq_r  <= last_seq_nxt;
      seq_valid_r <= seq_valid_nxt;
    end
  end

  // Time in state after this tick, saturating at the counter's full scale.
  assign t_sum = {1'b0, tis_r} + {7'd0, tick_period_r};
  assign t_sat = t_sum[16] ? 16'hFFFF : t_sum[15:0];

  assign link_drop = (state_r >= ST_DISCOVER) && (state_r <= ST_READY) && !item.link_up;

  // Where a tick would move the machine, link drop aside.
  always_comb begin
    target    = state_r;
    target_td = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (t_sat >= reconnect_r) target = ST_SCAN;
      end
      ST_SCAN, ST_CONNECTING: begin
        if (item.op_result == RES_DONE) target = ST_DISCOVER;
        else if (item.op_result == RES_FAIL) target = ST_ERROR;
      end
      ST_DISCOVER: begin
        if (item.op_result == RES_DONE) target = ST_PAIR;
        else if (item.op_result == RES_FAIL) target = ST_ERROR;
      end
      ST_PAIR, ST_SUBSCRIBE: begin
        if (item.op_result == RES_DONE)
          target = (state_r == ST_PAIR) ? ST_SUBSCRIBE : ST_READY;
        else if (item.op_result == RES_FAIL || t_sat >= secure_r)
          target = ST_BOND;
      end
      ST_BOND, ST_ERROR: begin
        if (t_sat >= reconnect_r) begin
          target    = ST_IDLE;
          target_td = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    blank           = '0;
    blank.new_state = state_r;

    state_nxt     = state_r;
    running_nxt   = running_r;
    tis_nxt       = tis_r;
    last_seq_nxt  = last_seq_r;
    seq_valid_nxt = seq_valid_r;
    res           = '0;
    res.r0        = blank;
    res.r1        = blank;

    case (item.command)
      CMD_TICK: begin
        if (running_r) begin
          if (link_drop) begin
            res.count           = 2'd2;
            res.r0.event_kind   = EV_DISC;
            res.r0.teardown     = 1'b1;
            res.r1.event_kind   = EV_STATE;
            res.r1.new_state    = ST_IDLE;
            state_nxt           = ST_IDLE;
            tis_nxt             = '0;
          end else if (target != state_r) begin
            res.count           = 2'd1;
            res.r0.event_kind   = EV_STATE;
            res.r0.new_state    = target;
            res.r0.teardown     = target_td;
            state_nxt           = target;
            tis_nxt             = '0;
          end else begin
            tis_nxt = t_sat;
          end
        end
      end
      CMD_START: begin
        if (!running_r) begin
          running_nxt   = 1'b1;
          seq_valid_nxt = 1'b0;
          if (state_r != ST_SCAN) begin
            res.count         = 2'd1;
            res.r0.event_kind = EV_STATE;
            res.r0.new_state  = ST_SCAN;
            state_nxt         = ST_SCAN;
            tis_nxt           = '0;
          end
        end
      end
      CMD_STOP: begin
        if (running_r) begin
          running_nxt = 1'b0;
          if (state_r != ST_IDLE) begin
            res.count         = 2'd1;
            res.r0.event_kind = EV_STATE;
            res.r0.new_state  = ST_IDLE;
            res.r0.teardown   = 1'b1;
            state_nxt         = ST_IDLE;
            tis_nxt           = '0;
          end
        end
      end
      CMD_SEND: begin
        res.count           = 2'd1;
        res.r0.event_kind   = EV_SEND;
        res.r0.send_granted = (state_r == ST_READY);
        res.r0.send_which   = item.send_kind;
      end
      CMD_MSG: begin
        // Button messages repeating the last sequence number are dropped.
        if (state_r == ST_READY &&
            !(item.msg_is_button && seq_valid_r && item.msg_seq == last_seq_r)) begin
          if (item.msg_is_button) begin
            last_seq_nxt  = item.msg_seq;
            seq_valid_nxt = 1'b1;
          end
          res.count         = 2'd1;
          res.r0.event_kind = EV_MSG;
          res.r0.msg_kind   = item.msg_kind;
          res.r0.msg_seq    = item.msg_seq;
        end
      end
      default: ;
    endcase

    res.r0.last = (res.count == 2'd1);
    res.r1.last = 1'b1;
  end

endmodule

// File: design/llc_out_queue.sv
// ----------------------------------------------------------------------------
// llc_out_queue
// Four-entry result queue taking up to two results per cycle, one out.
// ----------------------------------------------------------------------------
module llc_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  llc_pkg::res_bundle_t res,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output llc_pkg::result_t     head
);
  import llc_pkg::*;

  localparam logic [QPTR_W:0] MAX_FILL = (QPTR_W + 1)'(QUEUE_DEPTH - 2);

  result_t           q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic [1:0]        n_push;
  logic              pop;
  logic [QPTR_W-1:0] tail_p1;

  // Room means a transaction with two results still fits.
  assign room      = (count_r <= MAX_FILL);
  assign out_valid = (count_r != '0);
  assign head      = q_r[head_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? res.count : 2'd0;
  assign tail_p1   = tail_r + 1'b1;

  always_comb begin
    head_nxt  = pop ? head_r + 1'b1 : head_r;
    tail_nxt  = tail_r + QPTR_W'(n_push);
    count_nxt = count_r + (QPTR_W + 1)'(n_push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_r[tail_r]  <= res.r0;
    if (n_push == 2'd2) q_r[tail_p1] <= res.r1;
  end

endmodule

// File: design/link_lifecycle_controller_top.sv
// ----------------------------------------------------------------------------
// link_lifecycle_controller_top
// Connection lifecycle controller with streaming input and result channels.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries a command in in_tuser (tick, start,
// stop, send request or received message) and its operands in in_tdata.
// Ticks advance the lifecycle machine; each transaction yields zero, one or
// two result transactions on the out_ channel, the final one with out_tlast.
// out_tuser holds the event kind. Configuration is written on the cfg_
// channel (index 0 reconnect delay, 1 secure operation timeout, 2 tick
// period), which is always ready; write it only while the block is idle.
// An accepted input is registered in the input register and decided once
// the result queue has room; its results are written into that queue and
// offered from its head. Throughput: one input per cycle, bounded by
// the result queue, which drains one result per cycle while out_tready is
// high; inputs with two results therefore drain one result at a time.
// A stalled receiver fills the four-entry result queue; once it holds more
// than two results the input register holds and in_tready drops; nothing
// is lost.
// Reset (rst_n low, synchronous) returns to idle, stopped, with default
// configuration and empty queue.
// ----------------------------------------------------------------------------
module link_lifecycle_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] op_result, [2] link_up, [3] msg_is_button, [7:4] msg_kind,
  // [39:8] msg_seq, [40] send_kind, [47:41] zero
  input  logic [47:0] in_tdata,
  // [2:0] command
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] new_state, [7:4] out_msg_kind, [39:8] out_msg_seq,
  // [40] send_granted, [41] send_which, [42] teardown, [47:43] zero
  output logic [47:0] out_tdata,
  // [1:0] event_kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import llc_pkg::*;

  item_t       item_r;
  logic        item_valid_r, item_valid_nxt;
  logic        room;
  logic        commit;
  logic        in_fire;
  res_bundle_t res;
  result_t     head;
  cfg_wr_t     cfg;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign commit    = item_valid_r && room;
  assign in_tready = !item_valid_r || room;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_fire) item_valid_nxt = 1'b1;
    else if (commit) item_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.command       <= in_tuser;
      item_r.op_result     <= in_tdata[1:0];
      item_r.link_up       <= in_tdata[2];
      item_r.msg_is_button <= in_tdata[3];
      item_r.msg_kind      <= in_tdata[7:4];
      item_r.msg_seq       <= in_tdata[39:8];
      item_r.send_kind     <= in_tdata[40];
    end
  end

  llc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (item_r),
    .commit (commit),
    .res    (res)
  );

  llc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (commit),
    .res       (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = {5'd0, head.teardown, head.send_which, head.send_granted,
                      head.msg_seq, head.msg_kind, head.new_state};
  assign out_tuser = head.event_kind;
  assign out_tlast = head.last;

endmodule
